// File: design/lsmt_pkg.sv
// Shared types, codes and default timing constants of the LCD scanline mode timer.
`default_nettype none

package lsmt_pkg;

  // Default line timing, in clock cycles and lines.
  localparam int LINE_CYCLES_DEF     = 456;
  localparam int HBLANK_CYCLES_DEF   = 204;
  localparam int TRANSFER_CYCLES_DEF = 172;
  localparam int VISIBLE_LINES_DEF   = 144;
  localparam int TOTAL_LINES_DEF     = 154;

  // Field widths.
  localparam int BUDGET_W = 11;
  localparam int LINE_W   = 8;
  localparam int CYCLE_W  = 8;
  localparam int STATEN_W = 4;

  // Bottom of the signed line-cycle budget.
  localparam logic signed [BUDGET_W:0] BUDGET_MIN = -(12'sd1024);

  // STAT interrupt enable bits.
  localparam int STAT_EN_HBLANK = 0;
  localparam int STAT_EN_VBLANK = 1;
  localparam int STAT_EN_OAM    = 2;
  localparam int STAT_EN_LYC    = 3;

  typedef enum logic [1:0] {
    LCD_HBLANK     = 2'd0,
    LCD_VBLANK     = 2'd1,
    LCD_OAM_SCAN   = 2'd2,
    LCD_PIXEL_XFER = 2'd3
  } lcd_mode_t;

  typedef struct packed {
    logic signed [BUDGET_W-1:0] budget;
    logic [LINE_W-1:0]          line;
    lcd_mode_t                  mode;
  } lsmt_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    lcd_mode_t         lcd_mode;
    logic              line_match;
    logic              stat_irq;
    logic              vblank_irq;
    logic              draw_line;
    logic              frame_done;
  } lsmt_result_t;

endpackage

`default_nettype wire

// File: design/lsmt_step.sv
// Next-state and result logic for one burst of elapsed cycles.
`default_nettype none

module lsmt_step
  import lsmt_pkg::*;
#(
  parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
  parameter int HBLANK_CYCLES   = HBLANK_CYCLES_DEF,
  parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int TOTAL_LINES     = TOTAL_LINES_DEF
) (
  input  lsmt_state_t           state_i,
  input  logic [CYCLE_W-1:0]    elapsed_cycles,
  input  logic                  display_enable,
  input  logic [LINE_W-1:0]     line_compare,
  input  logic [STATEN_W-1:0]   stat_enables,
  output lsmt_state_t           state_o,
  output lsmt_result_t          result_o
);

  localparam logic signed [BUDGET_W+1:0] HB_TH = (BUDGET_W+2)'(HBLANK_CYCLES);
  localparam logic signed [BUDGET_W+1:0] HT_TH =
    (BUDGET_W+2)'(HBLANK_CYCLES + TRANSFER_CYCLES);
  localparam logic [LINE_W-1:0] VIS_LINE = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W-1:0] TOT_LINE = LINE_W'(TOTAL_LINES);

  logic signed [BUDGET_W:0]   b_diff;
  logic signed [BUDGET_W-1:0] b1;
  logic signed [BUDGET_W+1:0] b1_ext;
  logic signed [BUDGET_W:0]   b_add;
  logic                       b1_le0;
  logic [LINE_W-1:0]          inc;
  logic                       line_hit;
  logic                       inc_hit;
  logic                       zero_hit;
  logic                       adv;
  logic                       stat;
  logic                       vb;
  logic                       draw;
  lsmt_state_t                nxt;

  always_comb begin
    // Subtract the burst and clamp at the bottom of the budget range.
    b_diff = {state_i.budget[BUDGET_W-1], state_i.budget}
             - $signed({{(BUDGET_W+1-CYCLE_W){1'b0}}, elapsed_cycles});
    if (b_diff < BUDGET_MIN) begin
      b1 = BUDGET_MIN[BUDGET_W-1:0];
    end else begin
      b1 = b_diff[BUDGET_W-1:0];
    end
    b1_ext = {{2{b1[BUDGET_W-1]}}, b1};
    b1_le0 = b1[BUDGET_W-1] | (b1 == '0);
    b_add  = {b1[BUDGET_W-1], b1} + (BUDGET_W+1)'(LINE_CYCLES);

    inc      = state_i.line + LINE_W'(1);
    line_hit = (state_i.line == line_compare) & stat_enables[STAT_EN_LYC];
    inc_hit  = (inc == line_compare) & stat_enables[STAT_EN_LYC];
    zero_hit = (line_compare == '0) & stat_enables[STAT_EN_LYC];

    nxt  = state_i;
    stat = 1'b0;
    vb   = 1'b0;
    draw = 1'b0;
    adv  = 1'b0;

    if (!display_enable) begin
      nxt.budget = BUDGET_W'(LINE_CYCLES);
      nxt.line   = '0;
      nxt.mode   = LCD_HBLANK;
    end else begin
      nxt.budget = b1;
      if (state_i.line >= VIS_LINE) begin
        // VBlank lines: settle in VBlank, then advance when the line runs out.
        if (state_i.mode != LCD_VBLANK) begin
          stat     = line_hit | stat_enables[STAT_EN_VBLANK];
          nxt.mode = LCD_VBLANK;
        end
        adv = b1_le0;
      end else if (b1_le0) begin
        adv = 1'b1;
      end else if (b1_ext <= HB_TH) begin
        if (state_i.mode != LCD_HBLANK) begin
          stat     = line_hit | stat_enables[STAT_EN_HBLANK];
          nxt.mode = LCD_HBLANK;
        end
      end else if (b1_ext <= HT_TH) begin
        if (state_i.mode != LCD_PIXEL_XFER) begin
          draw     = 1'b1;
          stat     = line_hit;
          nxt.mode = LCD_PIXEL_XFER;
        end
      end else begin
        if (state_i.mode != LCD_OAM_SCAN) begin
          stat     = line_hit | stat_enables[STAT_EN_OAM];
          nxt.mode = LCD_OAM_SCAN;
        end
      end

      if (adv) begin
        nxt.budget = b_add[BUDGET_W-1:0];
        nxt.line   = inc;
        stat       = stat | inc_hit;
        if (inc == VIS_LINE) begin
          nxt.mode = LCD_VBLANK;
          stat     = stat | stat_enables[STAT_EN_VBLANK];
          vb       = 1'b1;
        end else if (inc >= TOT_LINE) begin
          // Past the last line of the frame: wrap to the top.
          nxt.line = '0;
          nxt.mode = LCD_OAM_SCAN;
          stat     = stat | zero_hit | stat_enables[STAT_EN_OAM];
        end else if (inc < VIS_LINE) begin
          nxt.mode = LCD_OAM_SCAN;
          stat     = stat | stat_enables[STAT_EN_OAM];
        end
      end
    end
  end

  assign state_o              = nxt;
  assign result_o.line_number = nxt.line;
  assign result_o.lcd_mode    = nxt.mode;
  assign result_o.line_match  = (nxt.line == line_compare);
  assign result_o.stat_irq    = stat;
  assign result_o.vblank_irq  = vb;
  assign result_o.draw_line   = draw;
  assign result_o.frame_done  = vb;

endmodule

`default_nettype wire

// File: design/lcd_scanline_mode_timer.sv
// Top level of the LCD scanline mode timer: input register, timing state and result register.
`default_nettype none

// Each input transfer carries a burst of elapsed clock cycles with the live LCD enable,
// LYC value and STAT interrupt enables; each one produces exactly one result transfer
// with LY, the mode, the LYC match flag and the interrupt and strobe pulses of that step.
// The block takes one transfer per clock cycle when the output side keeps up. Each
// accepted item is held in the input register, where the step logic works against
// the line-cycle budget, line and mode registers, and its result then waits in the
// result register until it is taken. Timing state is updated as an item leaves the
// input register, so back-to-back items see each other's effects in order. The result
// register lets a new input be taken while a finished result still waits, and a stall
// on the output side holds both stages in place. Reset puts the timer at line 0 in OAM
// scan with a full line of cycles in the budget.
module lcd_scanline_mode_timer
  import lsmt_pkg::*;
#(
  parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
  parameter int HBLANK_CYCLES   = HBLANK_CYCLES_DEF,
  parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF,
  parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
  parameter int TOTAL_LINES     = TOTAL_LINES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] elapsed_cycles, [8] display_enable, [16:9] line_compare,
  // [20:17] stat_enables, [23:21] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] line_number, [9:8] lcd_mode, [10] line_match, [11] stat_irq,
  // [12] vblank_irq, [13] draw_line, [15:14] zero
  output logic [15:0] out_tdata,
  // Frame done: set on the result that enters the first VBlank line.
  output logic        out_tlast
);

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [CYCLE_W-1:0]    s1_cycles_r;
  logic                  s1_enable_r;
  logic [LINE_W-1:0]     s1_lyc_r;
  logic [STATEN_W-1:0]   s1_en_r;
  logic                  s1_move;
  logic                  in_take;

  lsmt_state_t           state_r;
  lsmt_state_t           state_nxt;
  lsmt_result_t          step_res;
  lsmt_result_t          res_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;

  // The held item moves on when the result register is empty or being drained.
  assign s1_move   = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_move;
  assign in_take   = in_tvalid & in_tready;

  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_move);
  assign out_valid_nxt = s1_move | (out_valid_r & ~out_tready);

  lsmt_step #(
    .LINE_CYCLES    (LINE_CYCLES),
    .HBLANK_CYCLES  (HBLANK_CYCLES),
    .TRANSFER_CYCLES(TRANSFER_CYCLES),
    .VISIBLE_LINES  (VISIBLE_LINES),
    .TOTAL_LINES    (TOTAL_LINES)
  ) u_step (
    .state_i       (state_r),
    .elapsed_cycles(s1_cycles_r),
    .display_enable(s1_enable_r),
    .line_compare  (s1_lyc_r),
    .stat_enables  (s1_en_r),
    .state_o       (state_nxt),
    .result_o      (step_res)
  );

  // Control state and the timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r.budget <= BUDGET_W'(LINE_CYCLES);
      state_r.line   <= '0;
      state_r.mode   <= LCD_OAM_SCAN;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cycles_r <= in_tdata[7:0];
      s1_enable_r <= in_tdata[8];
      s1_lyc_r    <= in_tdata[16:9];
      s1_en_r     <= in_tdata[20:17];
    end
    if (s1_move) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.draw_line, res_r.vblank_irq, res_r.stat_irq,
                       res_r.line_match, res_r.lcd_mode, res_r.line_number};
  assign out_tlast  = res_r.frame_done;

endmodule

`default_nettype wire

// File: design/lsmt_checker.sv
// Port-level checker of the LCD scanline mode timer and its bind to the top level.
`default_nettype none

module lsmt_checker
  import lsmt_pkg::*;
#(
  parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
  parameter int TOTAL_LINES   = TOTAL_LINES_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("activity right after reset");

  // Frame done comes with the VBlank interrupt on the first VBlank line in VBlank mode.
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[12] && out_tdata[7:0] == 8'(VISIBLE_LINES) &&
      out_tdata[9:8] == LCD_VBLANK)
    else $error("frame done without VBlank entry");

  // The draw strobe only accompanies entry into transfer mode.
  a_draw_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> out_tdata[9:8] == LCD_PIXEL_XFER)
    else $error("draw strobe outside transfer");

  // The reported line stays inside the frame.
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] < 8'(TOTAL_LINES) ||
                   out_tdata[7:0] == 8'(VISIBLE_LINES))
    else $error("line number outside the frame");

endmodule

bind lcd_scanline_mode_timer lsmt_checker #(
  .VISIBLE_LINES(VISIBLE_LINES),
  .TOTAL_LINES  (TOTAL_LINES)
) u_lsmt_checker (.*);

`default_nettype wire
